// File: hw/rtl/sha1s_pkg.sv
package sha1s_pkg;

    // Initial chaining value
    localparam logic [31:0] INIT_CHAIN [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    // Padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Queue between front and core
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // One classified beat as it travels from front to core
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } q_entry_t;

endpackage

// File: hw/rtl/sha1_stream_hasher_unit.sv
// SHA-1 hasher fed one message byte per beat, digest returned as five 32-bit beats,
// most significant word first. A front stage drops beats that carry neither a byte
// nor an end mark and passes the rest through a four-entry queue to the core, so the
// input keeps flowing while the core compresses, until the queue fills. The core
// shifts in one byte per cycle while it is loading and an entry is waiting; each full
// 64-byte block then runs 80 rounds through one shared round unit and then the
// chaining add, during which no bytes are taken. At the end of a message the core
// pads one byte per cycle (up to 72 bytes, with one or two compressions) and then
// presents the five digest beats one per cycle while the output is taken; after the fifth
// beat it is ready for the next message. An item with byte_valid low and end_of_message
// high ends the message without a byte, so the empty message is hashed too.
module sha1_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        final_word
);

    logic                fr_valid;
    logic                fr_ready;
    sha1s_pkg::q_entry_t fr_ent;
    logic                q_valid;
    logic                q_ready;
    sha1s_pkg::q_entry_t q_ent;

    sha1s_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .msg_byte       (msg_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .ent_valid      (fr_valid),
        .ent            (fr_ent),
        .ent_ready      (fr_ready)
    );

    sha1s_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_ent   (fr_ent),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_ent    (q_ent)
    );

    sha1s_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ent_valid   (q_valid),
        .ent_ready   (q_ready),
        .ent         (q_ent),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .final_word  (final_word)
    );

endmodule

// File: hw/rtl/sha1s_front.sv
module sha1s_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          msg_byte,
    input  logic                byte_valid,
    input  logic                end_of_message,
    output logic                ent_valid,
    output sha1s_pkg::q_entry_t ent,
    input  logic                ent_ready
);

    logic                hold_valid_reg;
    logic                hold_valid_next;
    sha1s_pkg::q_entry_t hold_reg;
    sha1s_pkg::q_entry_t hold_next;
    logic                accept;
    logic                useful;

    // Take a new beat whenever the holding stage is empty or drains this cycle
    assign in_ready = !hold_valid_reg || ent_ready;
    assign accept   = in_valid && in_ready;
    // Drop beats that carry neither a byte nor an end mark
    assign useful   = byte_valid || end_of_message;

    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg && !ent_ready;
        if (accept)
        begin
            hold_valid_next    = useful;
            hold_next.data     = msg_byte;
            hold_next.has_byte = byte_valid;
            hold_next.last     = end_of_message;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign ent_valid = hold_valid_reg;
    assign ent       = hold_reg;

endmodule

// File: hw/rtl/sha1s_queue.sv
module sha1s_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  sha1s_pkg::q_entry_t push_ent,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sha1s_pkg::q_entry_t pop_ent
);

    sha1s_pkg::q_entry_t             mem [sha1s_pkg::QDEPTH];
    logic [sha1s_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sha1s_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sha1s_pkg::QCNT_W-1:0]    count_reg;
    logic [sha1s_pkg::QCNT_W-1:0]    count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != sha1s_pkg::QCNT_W'(sha1s_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_ent    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_ent;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sha1s_pkg::QCNT_W'(sha1s_pkg::QDEPTH))
        else $error("queue occupancy beyond depth");

endmodule

// File: hw/rtl/sha1s_core.sv
module sha1s_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ent_valid,
    output logic                ent_ready,
    input  sha1s_pkg::q_entry_t ent,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                final_word
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } core_state_t;

    core_state_t  st_reg, st_next;
    logic [31:0]  chain_reg [5];
    logic [31:0]  chain_next [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [511:0] win_reg, win_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  total_reg, total_next;
    logic [63:0]  len_reg, len_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic         pad_reg, pad_next;
    logic         first_reg, first_next;
    logic         lenph_reg, lenph_next;
    logic [2:0]   widx_reg, widx_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  digest_reg, digest_next;
    logic [2:0]   index_reg, index_next;
    logic         final_reg, final_next;

    logic         push_en;
    logic [7:0]   push_byte;
    logic         start_blk;
    logic         out_load;
    logic [63:0]  total_inc;
    logic [63:0]  total_msg;
    logic [31:0]  f_val, k_val, t_val, w_new, w_mix;
    logic [7:0]   len_byte;

    assign total_inc = total_reg + 64'd1;
    assign total_msg = ent.has_byte ? total_inc : total_reg;
    assign out_load  = !out_valid_reg || out_ready;
    assign ent_ready = (st_reg == ST_LOAD);
    assign len_byte  = len_reg[{~fill_reg[2:0], 3'b000} +: 8];

    // Round function and constant by round group
    always_comb
    begin
        case (rnd_reg) inside
            [7'd0:7'd19]:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = sha1s_pkg::K_R0;
            end
            [7'd20:7'd39]:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1s_pkg::K_R1;
            end
            [7'd40:7'd59]:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = sha1s_pkg::K_R2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1s_pkg::K_R3;
            end
        endcase
    end

    // Schedule: oldest word sits at the top of the window
    assign w_mix = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ win_reg[511:480];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + win_reg[511:480];

    // Sequencer
    always_comb
    begin
        st_next        = st_reg;
        chain_next     = chain_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        win_next       = win_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        len_next       = len_reg;
        rnd_next       = rnd_reg;
        pad_next       = pad_reg;
        first_next     = first_reg;
        lenph_next     = lenph_reg;
        widx_next      = widx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        digest_next    = digest_reg;
        index_next     = index_reg;
        final_next     = final_reg;
        push_en        = 1'b0;
        push_byte      = 8'h00;
        start_blk      = 1'b0;

        case (st_reg)
            ST_LOAD:
            begin
                if (ent_valid)
                begin
                    if (ent.has_byte)
                    begin
                        push_en    = 1'b1;
                        push_byte  = ent.data;
                        total_next = total_inc;
                    end
                    if (ent.last)
                    begin
                        len_next   = {total_msg[60:0], 3'b000};
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                    end
                    if (ent.has_byte && (fill_reg == 6'd63))
                    begin
                        start_blk = 1'b1;
                    end
                    else if (ent.last)
                    begin
                        st_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push_en    = 1'b1;
                first_next = 1'b0;
                if (first_reg)
                begin
                    push_byte = sha1s_pkg::PAD_MARK;
                end
                else if (lenph_reg || (fill_reg == 6'd56))
                begin
                    push_byte  = len_byte;
                    lenph_next = 1'b1;
                end
                if (fill_reg == 6'd63)
                begin
                    start_blk = 1'b1;
                end
            end
            ST_ROUND:
            begin
                e_next   = d_reg;
                d_next   = c_reg;
                c_next   = {b_reg[1:0], b_reg[31:2]};
                b_next   = a_reg;
                a_next   = t_val;
                win_next = {win_reg[479:0], w_new};
                if (rnd_reg == 7'd79)
                begin
                    rnd_next = '0;
                    st_next  = ST_ADD;
                end
                else
                begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                if (pad_reg && lenph_reg)
                begin
                    st_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    st_next = ST_PAD;
                end
                else
                begin
                    st_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    digest_next    = chain_reg[widx_reg];
                    index_next     = widx_reg;
                    final_next     = (widx_reg == 3'd4);
                    widx_next      = widx_reg + 1'b1;
                    if (widx_reg == 3'd4)
                    begin
                        // Return to the start state for the next message
                        chain_next = sha1s_pkg::INIT_CHAIN;
                        total_next = '0;
                        fill_next  = '0;
                        pad_next   = 1'b0;
                        first_next = 1'b0;
                        lenph_next = 1'b0;
                        widx_next  = '0;
                        st_next    = ST_LOAD;
                    end
                end
            end
            default:
            begin
                st_next = ST_LOAD;
            end
        endcase

        // Shift a byte into the block window
        if (push_en)
        begin
            win_next  = {win_reg[503:0], push_byte};
            fill_next = fill_reg + 1'b1;
        end

        // Open a compression with the current chaining value
        if (start_blk)
        begin
            a_next   = chain_reg[0];
            b_next   = chain_reg[1];
            c_next   = chain_reg[2];
            d_next   = chain_reg[3];
            e_next   = chain_reg[4];
            rnd_next = '0;
            st_next  = ST_ROUND;
        end
    end

    // Hold control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_LOAD;
            chain_reg     <= sha1s_pkg::INIT_CHAIN;
            fill_reg      <= '0;
            total_reg     <= '0;
            rnd_reg       <= '0;
            pad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            lenph_reg     <= 1'b0;
            widx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            rnd_reg       <= rnd_next;
            pad_reg       <= pad_next;
            first_reg     <= first_next;
            lenph_reg     <= lenph_next;
            widx_reg      <= widx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold datapath payload
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        win_reg    <= win_next;
        len_reg    <= len_next;
        digest_reg <= digest_next;
        index_reg  <= index_next;
        final_reg  <= final_next;
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = digest_reg;
    assign word_index  = index_reg;
    assign final_word  = final_reg;

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_ROUND) |-> (rnd_reg <= 7'd79))
        else $error("round counter past last round");

    a_round_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_ROUND) |-> (fill_reg == 6'd0))
        else $error("compression running on a partly filled block");

    a_len_place: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_PAD && lenph_reg) |-> (fill_reg[5:3] == 3'b111))
        else $error("length bytes outside the block tail");

    a_msg_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_OUT && out_load && widx_reg == 3'd4) |=>
        (st_reg == ST_LOAD && fill_reg == 6'd0 && total_reg == 64'd0 && !pad_reg))
        else $error("message state not cleared after digest");

endmodule
